// File: design/cbpg_pkg.sv
// Shared types and constants for the character/bitmap pixel generator.
package cbpg_pkg;

  localparam int PIX_W       = 8;
  localparam int VWORD_W     = 12;
  localparam int COLOR_W     = 4;
  localparam int COLORS_W    = PIX_W * COLOR_W;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ECM_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BITMAP_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MULTICOLOR_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR_ZERO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR_ONE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR_TWO    = 3'd5;

  // Multicolor pair codes
  localparam logic [1:0] PAIR_BG0  = 2'b00;
  localparam logic [1:0] PAIR_LOW  = 2'b01;
  localparam logic [1:0] PAIR_HIGH = 2'b10;
  localparam logic [1:0] PAIR_FG   = 2'b11;

  typedef struct packed {
    logic               ecm_enable;
    logic               bitmap_mode;
    logic               multicolor_mode;
    logic [COLOR_W-1:0] bg_color_zero;
    logic [COLOR_W-1:0] bg_color_one;
    logic [COLOR_W-1:0] bg_color_two;
  } cbpg_cfg_t;

endpackage

// File: design/character_bitmap_pixel_generator_core.sv
// Top level: input register, pixel decode and output register.
//
//  port group | dir | beat contents
//  in_*       | in  | tdata: gfx_byte[7:0], video_word[19:8]; tuser: display_active
//  out_*      | out | tdata: pixel_colors[31:0], foreground_mask[39:32]
//  cfg_*      | in  | write enable, register index, 4-bit data
//
// One beat per clock while out_tready holds high; an input beat reaches output
// valid through the input register, then the result register after the decode.
// Reset is synchronous, active low, and empties both stages.
// A stall on out_tready holds the result register and backs up through the
// input register; in_tready drops only when both stages are full.
module character_bitmap_pixel_generator_core
  import cbpg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // gfx_byte, video_word, pad
  input  logic                   in_tuser,   // display_active
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // pixel_colors, foreground_mask
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cbpg_cfg_t cfg;

  logic                 s1_valid_r;
  logic [PIX_W-1:0]     s1_pix_r;
  logic [VWORD_W-1:0]   s1_vw_r;
  logic                 s1_act_r;
  logic                 out_valid_r;
  logic [COLORS_W-1:0]  out_colors_r;
  logic [PIX_W-1:0]     out_mask_r;

  logic                 s2_ready;
  logic                 s1_ready;
  logic [COLORS_W-1:0]  dec_colors;
  logic [PIX_W-1:0]     dec_mask;

  cbpg_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cbpg_decode u_decode (
    .cfg             (cfg),
    .gfx_byte        (s1_pix_r),
    .video_word      (s1_vw_r),
    .display_active  (s1_act_r),
    .pixel_colors    (dec_colors),
    .foreground_mask (dec_mask)
  );

  // Each stage advances when the one after it is empty or draining
  assign s2_ready  = !out_valid_r || out_tready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload: capture input beat, then decoded result
  always_ff @(posedge clk) begin
    if (s1_ready && in_tvalid) begin
      s1_pix_r <= in_tdata[PIX_W-1:0];
      s1_vw_r  <= in_tdata[PIX_W+VWORD_W-1:PIX_W];
      s1_act_r <= in_tuser;
    end
    if (s2_ready && s1_valid_r) begin
      out_colors_r <= dec_colors;
      out_mask_r   <= dec_mask;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_mask_r, out_colors_r};

endmodule

// File: design/cbpg_cfg_regs.sv
// Mode and background colour register file behind the write port.
module cbpg_cfg_regs
  import cbpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cbpg_cfg_t             cfg
);

  cbpg_cfg_t cfg_r;
  cbpg_cfg_t cfg_nxt;

  // Decode the index; unknown indexes leave everything as it is
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ECM_ENABLE:      cfg_nxt.ecm_enable      = cfg_wdata[0];
        REG_BITMAP_MODE:     cfg_nxt.bitmap_mode     = cfg_wdata[0];
        REG_MULTICOLOR_MODE: cfg_nxt.multicolor_mode = cfg_wdata[0];
        REG_BG_COLOR_ZERO:   cfg_nxt.bg_color_zero   = cfg_wdata[COLOR_W-1:0];
        REG_BG_COLOR_ONE:    cfg_nxt.bg_color_one    = cfg_wdata[COLOR_W-1:0];
        REG_BG_COLOR_TWO:    cfg_nxt.bg_color_two    = cfg_wdata[COLOR_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/cbpg_decode.sv
// Combinational pixel decode for the four text/bitmap display modes and extended colour mode.
module cbpg_decode
  import cbpg_pkg::*;
(
  input  cbpg_cfg_t            cfg,
  input  logic [PIX_W-1:0]     gfx_byte,
  input  logic [VWORD_W-1:0]   video_word,
  input  logic                 display_active,
  output logic [COLORS_W-1:0]  pixel_colors,
  output logic [PIX_W-1:0]     foreground_mask
);

  logic [VWORD_W-1:0] vw;
  logic               bmp;
  logic               mc_sel;
  logic [COLOR_W-1:0] fg;
  logic [COLOR_W-1:0] bg;
  logic [COLOR_W-1:0] tab [4];
  logic [1:0]         bits;
  logic [COLOR_W-1:0] c;

  always_comb begin
    // Idle display: video word reads as zero and decodes as text
    vw  = display_active ? video_word : '0;
    bmp = display_active & cfg.bitmap_mode;
    mc_sel = cfg.multicolor_mode & (bmp | vw[VWORD_W-1]);

    fg = bmp ? vw[7:4] : vw[11:8];
    bg = bmp ? vw[3:0] : cfg.bg_color_zero;

    tab[PAIR_BG0]  = cfg.bg_color_zero;
    tab[PAIR_LOW]  = bmp ? vw[7:4] : cfg.bg_color_one;
    tab[PAIR_HIGH] = bmp ? vw[3:0] : cfg.bg_color_two;
    tab[PAIR_FG]   = vw[11:8];

    pixel_colors    = '0;
    foreground_mask = '0;
    bits = '0;
    c    = '0;

    if (cfg.ecm_enable) begin
      // Extended colour mode: all black, all background
      pixel_colors    = '0;
      foreground_mask = '0;
    end else if (mc_sel) begin
      // Double-width pixels, pairs 10 and 11 are foreground
      for (int g = 0; g < 4; g++) begin
        bits = gfx_byte[PIX_W-1-2*g -: 2];
        c    = tab[bits];
        pixel_colors[COLORS_W-1-8*g -: 8] = {c, c};
        foreground_mask[PIX_W-1-2*g -: 2] = {2{bits[1]}};
      end
    end else begin
      for (int p = 0; p < PIX_W; p++) begin
        pixel_colors[COLORS_W-1-COLOR_W*p -: COLOR_W] =
          gfx_byte[PIX_W-1-p] ? fg : bg;
        foreground_mask[PIX_W-1-p] = gfx_byte[PIX_W-1-p];
      end
    end
  end

endmodule

// File: design/cbpg_checker.sv
// Port-level checks for the pixel generator, bound to the top level.
module cbpg_checker
  import cbpg_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // With no result pending the pipeline cannot be backed up
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output stage empty");

  // An accepted beat reaches the output through the input and result registers when not stalled
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("result missing after accepted beat");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind character_bitmap_pixel_generator_core cbpg_checker u_cbpg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
